// ----- rtl/rsi_pkg.sv -----
// Package for the relative strength index block.
// Payload structs and fixed constants; no dependencies.
package rsi_pkg;

  localparam int PRICE_IN_W   = 32;
  localparam int PERIOD_W     = 7;
  localparam int RSI_W        = 15;
  localparam int PERIOD_RESET = 14;
  localparam int RSI_FULL     = 25600;
  // 25600 = 25 * 2**10
  localparam int SCALE_SHIFT  = 10;

  typedef struct packed {
    logic [PRICE_IN_W-1:0] price;
    logic                  first_of_series;
  } in_t;

  typedef struct packed {
    logic [RSI_W-1:0] rsi;
    logic             rsi_valid;
  } out_t;

endpackage

// ----- rtl/rsi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read returns the old contents on a same-address write.
module rsi_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ----- rtl/relative_strength_index.sv -----
// Relative strength index (simple moving window), RSI*256 per price transaction.
// An accepted price runs S_READ, S_UPDATE, S_SCALE, the 15-step divider in S_DIV, then
// S_OUT; an invalid or zero-loss result skips S_DIV, and the first price of a series goes
// straight to S_OUT. Prices are taken only in S_IDLE, after the last result is registered;
// a held result stalls the input until out_ready. Reset (rst_n, synchronous): period 14,
// sums, history count and ring pointer cleared. Depends on rsi_pkg and rsi_ram.
module relative_strength_index #(
  parameter int PERIOD_MAX  = 64,
  parameter int PRICE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rsi_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rsi_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rsi_pkg::PERIOD_W-1:0]  cfg_data
);

  import rsi_pkg::*;

  localparam int PW     = (PRICE_WIDTH < PRICE_IN_W) ? PRICE_WIDTH : PRICE_IN_W;
  localparam int CH_W   = PW + 1;
  localparam int SUM_W  = PW + $clog2(PERIOD_MAX);
  localparam int P_W    = $clog2(PERIOD_MAX + 1);
  localparam int CW     = (P_W > PERIOD_W) ? P_W : PERIOD_W;
  localparam int I_W    = $clog2(PERIOD_MAX + 2);
  localparam int PTR_W  = $clog2(PERIOD_MAX);
  localparam int LO_HI  = RSI_W - SCALE_SHIFT;
  localparam int N_W    = SUM_W + LO_HI;
  localparam int CNT_W  = $clog2(RSI_W);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(RSI_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_SCALE,
    S_DIV,
    S_OUT
  } state_t;

  state_t                state_r, state_nxt;
  logic [PERIOD_W-1:0]   period_r, period_nxt;
  logic [PW-1:0]         prev_r, prev_nxt;
  logic [SUM_W-1:0]      gain_r, gain_nxt;
  logic [SUM_W-1:0]      loss_r, loss_nxt;
  logic [I_W-1:0]        items_r, items_nxt;
  logic [PTR_W-1:0]      ptr_r, ptr_nxt;
  logic [PTR_W-1:0]      wptr_r, wptr_nxt;
  logic signed [CH_W-1:0] change_r, change_nxt;
  logic                  remove_r, remove_nxt;
  logic [SUM_W-1:0]      rem_r, rem_nxt;
  logic [SUM_W-1:0]      den_r, den_nxt;
  logic [RSI_W-1:0]      lo_r, lo_nxt;
  logic [RSI_W-1:0]      quo_r, quo_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  out_t                  pend_r, pend_nxt;
  out_t                  out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [P_W-1:0]        p_eff;
  logic [P_W:0]          old_t;
  logic [P_W:0]          old_w;
  logic [PTR_W-1:0]      raddr;
  logic                  ram_we;
  logic [CH_W-1:0]       rdata;
  logic signed [CH_W-1:0] old_chg;
  logic signed [CH_W-1:0] old_neg;
  logic signed [CH_W-1:0] new_neg;
  logic [PW-1:0]         price_m;
  logic                  first;
  logic [N_W-1:0]        n25;
  logic [SUM_W:0]        shifted;
  logic [SUM_W:0]        diff;

  always_comb begin
    if (period_r == '0) begin
      p_eff = P_W'(1);
    end else if (CW'(period_r) > CW'(PERIOD_MAX)) begin
      p_eff = P_W'(PERIOD_MAX);
    end else begin
      p_eff = P_W'(period_r);
    end
  end

  // slot that drops out of the window: (ptr - p) mod PERIOD_MAX
  assign old_t = (P_W+1)'(ptr_r) + (P_W+1)'(PERIOD_MAX) - (P_W+1)'(p_eff);
  assign old_w = (old_t >= (P_W+1)'(PERIOD_MAX)) ? old_t - (P_W+1)'(PERIOD_MAX) : old_t;
  assign raddr = PTR_W'(old_w);
  assign ram_we = (state_r == S_READ);

  rsi_ram #(
    .WIDTH (CH_W),
    .DEPTH (PERIOD_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata (change_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign old_chg = signed'(rdata);
  assign old_neg = -old_chg;
  assign new_neg = -change_r;
  assign price_m = in_data.price[PW-1:0];
  assign first   = in_data.first_of_series || (items_r == '0);
  assign n25     = (N_W'(gain_r) << 4) + (N_W'(gain_r) << 3) + N_W'(gain_r);
  assign shifted = {rem_r, lo_r[RSI_W-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    state_nxt     = state_r;
    period_nxt    = period_r;
    prev_nxt      = prev_r;
    gain_nxt      = gain_r;
    loss_nxt      = loss_r;
    items_nxt     = items_r;
    ptr_nxt       = ptr_r;
    wptr_nxt      = wptr_r;
    change_nxt    = change_r;
    remove_nxt    = remove_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    lo_nxt        = lo_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          prev_nxt = price_m;
          if (first) begin
            gain_nxt  = '0;
            loss_nxt  = '0;
            items_nxt = I_W'(1);
            ptr_nxt   = '0;
            pend_nxt  = '{rsi: '0, rsi_valid: 1'b0};
            state_nxt = S_OUT;
          end else begin
            change_nxt = signed'({1'b0, price_m}) - signed'({1'b0, prev_r});
            remove_nxt = (items_r > I_W'(p_eff));
            wptr_nxt   = ptr_r;
            ptr_nxt    = (ptr_r == PTR_W'(PERIOD_MAX - 1)) ? '0 : ptr_r + 1'b1;
            if (items_r <= I_W'(PERIOD_MAX)) begin
              items_nxt = items_r + 1'b1;
            end
            state_nxt  = S_READ;
          end
        end
      end
      S_READ: begin
        if (remove_r) begin
          if (old_chg > 0) begin
            gain_nxt = gain_r - SUM_W'(old_chg[PW-1:0]);
          end else begin
            loss_nxt = loss_r - SUM_W'(old_neg[PW-1:0]);
          end
        end
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (change_r > 0) begin
          gain_nxt = gain_r + SUM_W'(change_r[PW-1:0]);
        end else begin
          loss_nxt = loss_r + SUM_W'(new_neg[PW-1:0]);
        end
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        if (!(items_r > I_W'(p_eff))) begin
          pend_nxt  = '{rsi: '0, rsi_valid: 1'b0};
          state_nxt = S_OUT;
        end else if (loss_r == '0) begin
          pend_nxt  = '{rsi: RSI_W'(RSI_FULL), rsi_valid: 1'b1};
          state_nxt = S_OUT;
        end else begin
          rem_nxt   = n25[N_W-1:LO_HI];
          lo_nxt    = {n25[LO_HI-1:0], SCALE_SHIFT'(0)};
          den_nxt   = gain_r + loss_r;
          quo_nxt   = '0;
          cnt_nxt   = DIV_LAST;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!diff[SUM_W]) begin
          rem_nxt = SUM_W'(diff);
          quo_nxt = {quo_r[RSI_W-2:0], 1'b1};
        end else begin
          rem_nxt = SUM_W'(shifted);
          quo_nxt = {quo_r[RSI_W-2:0], 1'b0};
        end
        lo_nxt  = {lo_r[RSI_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          pend_nxt  = '{rsi: quo_nxt, rsi_valid: 1'b1};
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a period write restarts the series
    if (cfg_valid) begin
      period_nxt = cfg_data;
      items_nxt  = '0;
      ptr_nxt    = '0;
      gain_nxt   = '0;
      loss_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= PERIOD_W'(PERIOD_RESET);
      prev_r      <= '0;
      gain_r      <= '0;
      loss_r      <= '0;
      items_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      prev_r      <= prev_nxt;
      gain_r      <= gain_nxt;
      loss_r      <= loss_nxt;
      items_r     <= items_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wptr_r   <= wptr_nxt;
    change_r <= change_nxt;
    remove_r <= remove_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    lo_r     <= lo_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.rsi <= RSI_W'(RSI_FULL))
    else $error("rsi above full scale");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.rsi_valid |-> out_data.rsi == '0)
    else $error("invalid transaction carries a nonzero rsi");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < den_r)
    else $error("divider remainder not below divisor");

  a_items_sat: assert property (@(posedge clk) disable iff (!rst_n)
    items_r <= I_W'(PERIOD_MAX + 1))
    else $error("history count past saturation");

endmodule

// ----- test/tb_relative_strength_index.sv -----
// Testbench for relative_strength_index: drives price transactions, predicts RSI*256
// from its own moving-window sums and checks each result transaction in order.
// Depends on rsi_pkg and the relative_strength_index RTL.
`timescale 1ns / 100ps

module tb_relative_strength_index;
  import rsi_pkg::*;

  localparam int PERIOD_MAX      = 64;
  localparam int DRAIN_CYCLES    = 25;
  localparam int ITEMS_PER_PHASE = 200;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [PERIOD_W-1:0] cfg_data;

  // predictor state
  logic [PERIOD_W-1:0] period_q;
  logic [31:0]         last_price;
  logic signed [32:0]  change_hist [PERIOD_MAX];
  logic [37:0]         gain_sum;
  logic [37:0]         loss_sum;
  int unsigned         series_len;
  int unsigned         wr_slot;

  out_t expected_rsi [$];
  out_t head;
  int   mismatches = 0;

  relative_strength_index #(
    .PERIOD_MAX (PERIOD_MAX),
    .PRICE_WIDTH(32)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_series();
    gain_sum   = '0;
    loss_sum   = '0;
    series_len = 0;
    wr_slot    = 0;
  endfunction

  function automatic void apply_change(logic signed [32:0] delta, bit drop);
    logic [37:0] mag;
    mag = (delta > 0) ? 38'(delta) : 38'(-delta);
    if (delta > 0) begin
      gain_sum = drop ? gain_sum - mag : gain_sum + mag;
    end else begin
      loss_sum = drop ? loss_sum - mag : loss_sum + mag;
    end
  endfunction

  function automatic out_t predict_rsi(in_t item);
    out_t               res;
    int unsigned        win;
    logic signed [32:0] delta;
    logic [63:0]        num;
    logic [63:0]        den;
    res = '0;
    win = (period_q == 0) ? 1 : (period_q > PERIOD_MAX) ? PERIOD_MAX : period_q;
    if (item.first_of_series || series_len == 0) begin
      clear_series();
      series_len = 1;
    end else begin
      delta = $signed({1'b0, item.price}) - $signed({1'b0, last_price});
      if (series_len - 1 >= win) begin
        apply_change(change_hist[(wr_slot + PERIOD_MAX - win) % PERIOD_MAX], 1'b1);
      end
      change_hist[wr_slot] = delta;
      wr_slot = (wr_slot + 1) % PERIOD_MAX;
      apply_change(delta, 1'b0);
      if (series_len <= PERIOD_MAX) series_len++;
      if (series_len > win) begin
        res.rsi_valid = 1'b1;
        if (loss_sum == 0) begin
          res.rsi = RSI_W'(RSI_FULL);
        end else begin
          num = 64'(gain_sum) * 64'(RSI_FULL);
          den = 64'(gain_sum) + 64'(loss_sum);
          res.rsi = RSI_W'(num / den);
        end
      end
    end
    last_price = item.price;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < 50) begin
      $display("%0t ERROR rsi check: %s got %0d expected %0d", $time, field, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_rsi.size() == 0) begin
        report_mismatch("unexpected transaction, rsi", out_data.rsi, 0);
      end else begin
        head = expected_rsi.pop_front();
        if (out_data.rsi !== head.rsi) report_mismatch("rsi", out_data.rsi, head.rsi);
        if (out_data.rsi_valid !== head.rsi_valid) begin
          report_mismatch("rsi_valid", out_data.rsi_valid, head.rsi_valid);
        end
      end
    end
  end

  // receiver: free-running, random, or one-in-k ready
  initial begin
    int unsigned mode, left, k, cnt;
    out_ready = 1'b0;
    left = 0;
    k = 2;
    cnt = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(50, 400);
        k = $urandom_range(2, 12);
      end
      left--;
      cnt++;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= (cnt % k == 0);
      endcase
    end
  end

  task automatic send_price(input logic [31:0] price, input logic first);
    in_t item;
    item.price = price;
    item.first_of_series = first;
    @(negedge clk);
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_rsi.push_back(predict_rsi(item));
  endtask

  task automatic idle_cycles(input int unsigned n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_rsi.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    period_q = value;
    clear_series();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // series starts without the flag after reset; period still at its reset value
  task automatic test_flat_start();
    send_price(32'h1234_5678, 1'b0);
    send_price(32'h1234_9999, 1'b0);
    send_price(32'h0000_0001, 1'b0);
  endtask

  // period 0 acts as 1: full-scale gain, full-scale loss, then a flat step
  task automatic test_window_of_one();
    write_period(7'd0);
    send_price(32'h0000_0000, 1'b1);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'h0000_0000, 1'b0);
    send_price(32'h0000_0000, 1'b0);
  endtask

  task automatic test_gain_loss_mix();
    write_period(7'd2);
    send_price(32'h0001_0000, 1'b1);
    send_price(32'h0002_0000, 1'b0);
    send_price(32'h0003_0000, 1'b0);
    send_price(32'h0002_8000, 1'b0);
    send_price(32'h7FFF_FFFF, 1'b1);
    send_price(32'h8000_0000, 1'b0);
    send_price(32'h7FFF_0000, 1'b0);
  endtask

  // period above the ring depth is clamped
  task automatic test_period_clamp();
    write_period(7'd127);
    send_price(32'hAAAA_5555, 1'b0);
    send_price(32'h5555_AAAA, 1'b0);
    send_price(32'h5555_AAAB, 1'b0);
  endtask

  task automatic test_random_series();
    logic [PERIOD_W-1:0] plan [10];
    int unsigned         burst_left, trend, win;
    logic [31:0]         walk, step;
    logic                first, up;
    bit                  gaps_on;
    plan = '{7'd1, 7'd64, 7'd3, 7'd14, 7'd127, 7'd2, 7'd0, 7'd65, 7'd5, 7'd9};
    plan[8] = PERIOD_W'($urandom_range(1, 40));
    plan[9] = PERIOD_W'($urandom_range(0, 127));
    walk = $urandom();
    trend = 0;
    burst_left = 0;
    foreach (plan[ph]) begin
      write_period(plan[ph]);
      win = (plan[ph] == 0) ? 1 : (plan[ph] > PERIOD_MAX) ? PERIOD_MAX : plan[ph];
      gaps_on = (ph % 3 != 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        first = (n == 0) || ($urandom_range(0, 3 * win + 20) == 0);
        if (first) trend = $urandom_range(0, 2);
        if ($urandom_range(0, 19) == 0) begin
          walk = $urandom();
        end else if ($urandom_range(0, 9) != 0) begin
          step = $urandom_range(0, 1 << $urandom_range(0, 20));
          if (trend == 0) up = ($urandom_range(0, 1) == 1);
          else up = ((trend == 1) == ($urandom_range(0, 9) != 0));
          walk = up ? walk + step : walk - step;
        end
        if (gaps_on) begin
          if (burst_left == 0) begin
            idle_cycles($urandom_range(1, 30));
            burst_left = $urandom_range(1, 12);
          end
          burst_left--;
        end
        send_price(walk, first);
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    period_q   = PERIOD_W'(PERIOD_RESET);
    last_price = '0;
    clear_series();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_flat_start();
    test_window_of_one();
    test_gain_loss_mix();
    test_period_clamp();
    test_random_series();

    drain_results();
    if (mismatches == 0) begin
      $display("relative_strength_index: match");
    end else begin
      $display("relative_strength_index: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("relative_strength_index: mismatch");
    $finish;
  end

endmodule
